/* rtl/vpd_pkg.sv */
// ----------------------------------------------------------------------------
// vpd_pkg
// Shared constants, command codes and helper tables for the vision PD
// heading controller.
// ----------------------------------------------------------------------------
package vpd_pkg;

  localparam int COORD_WIDTH_DEF  = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  // port field widths
  localparam int FIELD_W   = 16;
  localparam int IN_DATA_W = 8 * FIELD_W;
  localparam int HEAD_W    = 15;
  localparam int DIST_W    = 17;
  localparam int PWR_W     = 11;
  localparam int OUT_RAW_W = 2 * HEAD_W + DIST_W + 2 * PWR_W;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  // config port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_POWER = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_P_GAIN    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_D_GAIN    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_DOWN = 8'd3;

  // fixed-point constants
  localparam int GUARD_SHIFT = 8;
  localparam int ANG_W       = 27;
  localparam int STEP_W      = 5;
  localparam int MAX_STEPS   = 24;
  localparam int INV_W       = 22;
  localparam logic [INV_W-1:0] INV_GAIN_Q22 = 22'd2547003;
  localparam logic signed [ANG_W-1:0] DEG180 = 27'sd11796480;
  localparam logic signed [ANG_W-1:0] DEG90  = 27'sd5898240;
  localparam logic signed [15:0] HALF_TURN   = 16'sd11520;
  localparam logic signed [15:0] FULL_TURN   = 16'sd23040;
  localparam logic [9:0] POWER_FULL          = 10'd1000;
  localparam logic [DIST_W-1:0] DIST_MAX     = 17'd131071;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_SETUP, OP_ITER, OP_MUL, OP_FIN,
    OP_PDP, OP_PDD, OP_DRV, OP_PUSH
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [STEP_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic is_target;
    logic out_busy;
  } status_t;

  // arctan(2^-i) in 1/65536 degree
  function automatic logic signed [ANG_W-1:0] atan_lut(input logic [STEP_W-1:0] i);
    logic signed [ANG_W-1:0] v;
    case (i)
      5'd0:  v = 27'sd2949120;
      5'd1:  v = 27'sd1740967;
      5'd2:  v = 27'sd919879;
      5'd3:  v = 27'sd466945;
      5'd4:  v = 27'sd234379;
      5'd5:  v = 27'sd117304;
      5'd6:  v = 27'sd58666;
      5'd7:  v = 27'sd29335;
      5'd8:  v = 27'sd14668;
      5'd9:  v = 27'sd7334;
      5'd10: v = 27'sd3667;
      5'd11: v = 27'sd1833;
      5'd12: v = 27'sd917;
      5'd13: v = 27'sd458;
      5'd14: v = 27'sd229;
      5'd15: v = 27'sd115;
      5'd16: v = 27'sd57;
      5'd17: v = 27'sd29;
      5'd18: v = 27'sd14;
      5'd19: v = 27'sd7;
      5'd20: v = 27'sd4;
      5'd21: v = 27'sd2;
      5'd22: v = 27'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/vpd_ctrl.sv */
// ----------------------------------------------------------------------------
// vpd_ctrl
// Sequencer: load, cordic setup, iterations, scaling, PD law, result push.
// ----------------------------------------------------------------------------
module vpd_ctrl #(
  parameter int CORDIC_STEPS = vpd_pkg::CORDIC_STEPS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  vpd_pkg::status_t status_i,
  output vpd_pkg::cmd_t    cmd_o
);

  localparam int NSTEPS = (CORDIC_STEPS > vpd_pkg::MAX_STEPS) ?
                          vpd_pkg::MAX_STEPS : CORDIC_STEPS;
  localparam logic [vpd_pkg::STEP_W-1:0] LAST = vpd_pkg::STEP_W'(NSTEPS - 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SETUP, ST_ITER, ST_MUL, ST_FIN, ST_PDP, ST_PDD, ST_DRV, ST_PUSH
  } state_e;

  state_e                     state_q;
  logic [vpd_pkg::STEP_W-1:0] step_q;

  // state register and step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE:  if (in_valid_i) state_q <= ST_SETUP;
        ST_SETUP: begin
          step_q  <= '0;
          state_q <= ST_ITER;
        end
        ST_ITER: begin
          step_q <= step_q + 1'b1;
          if (step_q == LAST) state_q <= ST_MUL;
        end
        ST_MUL:   state_q <= ST_FIN;
        ST_FIN:   state_q <= status_i.is_target ? ST_PDP : ST_PUSH;
        ST_PDP:   state_q <= ST_PDD;
        ST_PDD:   state_q <= ST_DRV;
        ST_DRV:   state_q <= ST_PUSH;
        ST_PUSH:  if (!status_i.out_busy) state_q <= ST_IDLE;
        default:  state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  // command decode
  always_comb begin
    cmd_o.step = step_q;
    unique case (state_q)
      ST_IDLE:  cmd_o.op = in_valid_i ? vpd_pkg::OP_LOAD : vpd_pkg::OP_NONE;
      ST_SETUP: cmd_o.op = vpd_pkg::OP_SETUP;
      ST_ITER:  cmd_o.op = vpd_pkg::OP_ITER;
      ST_MUL:   cmd_o.op = vpd_pkg::OP_MUL;
      ST_FIN:   cmd_o.op = vpd_pkg::OP_FIN;
      ST_PDP:   cmd_o.op = vpd_pkg::OP_PDP;
      ST_PDD:   cmd_o.op = vpd_pkg::OP_PDD;
      ST_DRV:   cmd_o.op = vpd_pkg::OP_DRV;
      ST_PUSH:  cmd_o.op = status_i.out_busy ? vpd_pkg::OP_NONE : vpd_pkg::OP_PUSH;
      default:  cmd_o.op = vpd_pkg::OP_NONE;
    endcase
  end

endmodule

/* rtl/vpd_datapath.sv */
// ----------------------------------------------------------------------------
// vpd_datapath
// Pose and target vectors, shared vectoring CORDIC, magnitude scaling,
// PD law and the output register.
// ----------------------------------------------------------------------------
module vpd_datapath #(
  parameter int COORD_WIDTH = vpd_pkg::COORD_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  vpd_pkg::cmd_t                   cmd_i,
  output vpd_pkg::status_t                status_o,
  input  logic                            req_type_i,
  input  logic [vpd_pkg::IN_DATA_W-1:0]   in_data_i,
  input  logic                            cfg_we_i,
  input  logic [vpd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [vpd_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [vpd_pkg::OUT_DATA_W-1:0]  out_data_o,
  output logic                            out_fresh_o
);

  localparam int CW = COORD_WIDTH;
  localparam int VW = CW + 1;
  localparam int XW = VW + vpd_pkg::GUARD_SHIFT + 2;
  localparam int PW = XW + vpd_pkg::INV_W;
  localparam int FW = vpd_pkg::FIELD_W;
  localparam int AW = vpd_pkg::ANG_W;

  // configuration registers
  logic [9:0]         max_power_q;
  logic signed [15:0] p_gain_q, d_gain_q;
  logic               base_down_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_power_q <= vpd_pkg::POWER_FULL;
      p_gain_q    <= 16'sd256;
      d_gain_q    <= '0;
      base_down_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        vpd_pkg::REG_MAX_POWER: max_power_q <= cfg_data_i[9:0];
        vpd_pkg::REG_P_GAIN:    p_gain_q    <= cfg_data_i;
        vpd_pkg::REG_D_GAIN:    d_gain_q    <= cfg_data_i;
        vpd_pkg::REG_BASE_DOWN: base_down_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // input coordinates
  logic [CW-1:0] ax, ay, bx, by, cx, cy, tx, ty;
  assign ax = CW'(in_data_i[0*FW +: FW]);
  assign ay = CW'(in_data_i[1*FW +: FW]);
  assign bx = CW'(in_data_i[2*FW +: FW]);
  assign by = CW'(in_data_i[3*FW +: FW]);
  assign cx = CW'(in_data_i[4*FW +: FW]);
  assign cy = CW'(in_data_i[5*FW +: FW]);
  assign tx = CW'(in_data_i[6*FW +: FW]);
  assign ty = CW'(in_data_i[7*FW +: FW]);

  logic [VW-1:0] sum_x, sum_y;
  assign sum_x = VW'(ax) + VW'(cx);
  assign sum_y = VW'(ay) + VW'(cy);

  // held state
  logic [CW-1:0]              center_x_q, center_y_q;
  logic signed [15:0]         heading_q, bearing_q, prev_q;
  logic [vpd_pkg::DIST_W-1:0] dist_q;
  logic signed [vpd_pkg::PWR_W-1:0] left_q, right_q;

  // per-item working registers
  logic                 tgt_q, zero_q, vxneg_q;
  logic signed [VW-1:0] vx_q, vy_q;
  logic signed [XW-1:0] x_q, y_q;
  logic signed [AW-1:0] z_q;
  logic [PW-1:0]        prod_q;
  logic signed [15:0]   ang_q;
  logic [9:0]           mp_q;
  logic signed [31:0]   m1_q, m2_q;

  // setup: base-relative vector and quadrant pre-rotation
  logic signed [VW-1:0] bys, avx;
  logic signed [XW-1:0] x0, y0;
  assign bys = base_down_q ? vy_q : -vy_q;
  assign avx = vx_q[VW-1] ? -vx_q : vx_q;
  assign x0  = XW'(bys) <<< vpd_pkg::GUARD_SHIFT;
  assign y0  = XW'(avx) <<< vpd_pkg::GUARD_SHIFT;

  // one cordic micro-rotation
  logic signed [XW-1:0] xs, ys;
  assign xs = x_q >>> cmd_i.step;
  assign ys = y_q >>> cmd_i.step;

  // angle against base, rounded to 1/64 degree
  logic signed [AW-1:0] d_ang, d_rnd;
  assign d_ang = vxneg_q ? (vpd_pkg::DEG180 + z_q) : (vpd_pkg::DEG180 - z_q);
  assign d_rnd = (d_ang + AW'(512)) >>> 10;

  // magnitude rounding and saturation
  logic [PW-1:0] mag_full;
  assign mag_full = (prod_q + (PW'(1) << 29)) >> 30;

  // bearing wrap
  logic signed [15:0] ta, turn, turn_w;
  assign ta   = zero_q ? vpd_pkg::HALF_TURN : ang_q;
  assign turn = ta - heading_q;
  always_comb begin
    if (turn > vpd_pkg::HALF_TURN)       turn_w = turn - vpd_pkg::FULL_TURN;
    else if (turn < -vpd_pkg::HALF_TURN) turn_w = turn + vpd_pkg::FULL_TURN;
    else                                 turn_w = turn;
  end

  // PD drive law
  logic signed [32:0] u;
  logic signed [33:0] lim, l_raw, r_raw, l_cl, r_cl;
  assign u     = 33'(m1_q) + 33'(m2_q);
  assign lim   = $signed({10'd0, mp_q, 14'd0});
  assign l_raw = lim + 34'(u);
  assign r_raw = lim - 34'(u);
  always_comb begin
    l_cl = (l_raw > lim) ? lim : ((l_raw < -lim) ? -lim : l_raw);
    r_cl = (r_raw > lim) ? lim : ((r_raw < -lim) ? -lim : r_raw);
  end

  function automatic logic signed [vpd_pkg::PWR_W-1:0] round_pwr(
    input logic signed [33:0] r
  );
    logic signed [33:0] a;
    logic signed [33:0] q;
    a = r[33] ? -r : r;
    q = (a + 34'sd8192) >>> 14;
    return r[33] ? -vpd_pkg::PWR_W'(q) : vpd_pkg::PWR_W'(q);
  endfunction

  // working datapath
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      vpd_pkg::OP_LOAD: begin
        tgt_q <= req_type_i;
        if (req_type_i) begin
          vx_q <= VW'(tx) - VW'(center_x_q);
          vy_q <= VW'(ty) - VW'(center_y_q);
        end else begin
          vx_q <= VW'(bx) - VW'(cx);
          vy_q <= VW'(by) - VW'(cy);
        end
      end
      vpd_pkg::OP_SETUP: begin
        zero_q  <= (vx_q == '0) && (vy_q == '0);
        vxneg_q <= vx_q[VW-1];
        if (x0[XW-1]) begin
          x_q <= y0;
          y_q <= -x0;
          z_q <= vpd_pkg::DEG90;
        end else begin
          x_q <= x0;
          y_q <= y0;
          z_q <= '0;
        end
      end
      vpd_pkg::OP_ITER: begin
        if (y_q > 0) begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + vpd_pkg::atan_lut(cmd_i.step);
        end else begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - vpd_pkg::atan_lut(cmd_i.step);
        end
      end
      vpd_pkg::OP_MUL: begin
        prod_q <= PW'(x_q[XW-2:0]) * PW'(vpd_pkg::INV_GAIN_Q22);
        ang_q  <= 16'(d_rnd);
      end
      vpd_pkg::OP_PDP: begin
        mp_q <= (max_power_q > vpd_pkg::POWER_FULL) ? vpd_pkg::POWER_FULL : max_power_q;
        m1_q <= p_gain_q * bearing_q;
      end
      vpd_pkg::OP_PDD: begin
        m2_q <= d_gain_q * (prev_q - bearing_q);
      end
      default: ;
    endcase
  end

  // held state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      heading_q  <= '0;
      bearing_q  <= '0;
      prev_q     <= '0;
      dist_q     <= '0;
      left_q     <= '0;
      right_q    <= '0;
    end else begin
      if (cmd_i.op == vpd_pkg::OP_LOAD && !req_type_i) begin
        center_x_q <= sum_x[CW:1];
        center_y_q <= sum_y[CW:1];
      end
      if (cmd_i.op == vpd_pkg::OP_FIN) begin
        if (!tgt_q) begin
          heading_q <= zero_q ? '0 : ang_q;
        end else begin
          if (zero_q)                                 dist_q <= '0;
          else if (mag_full > PW'(vpd_pkg::DIST_MAX)) dist_q <= vpd_pkg::DIST_MAX;
          else                                        dist_q <= vpd_pkg::DIST_W'(mag_full);
          prev_q    <= bearing_q;
          bearing_q <= turn_w;
        end
      end
      if (cmd_i.op == vpd_pkg::OP_DRV) begin
        if (u > 0) begin
          left_q  <= $signed({1'b0, mp_q});
          right_q <= round_pwr(r_cl);
        end else begin
          left_q  <= round_pwr(l_cl);
          right_q <= $signed({1'b0, mp_q});
        end
      end
    end
  end

  // output register
  logic out_valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == vpd_pkg::OP_PUSH) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == vpd_pkg::OP_PUSH) begin
      out_data_o  <= vpd_pkg::OUT_DATA_W'({right_q, left_q, dist_q,
                                           bearing_q[14:0], heading_q[14:0]});
      out_fresh_o <= tgt_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o.out_busy  = out_valid_q && !out_ready_i;
  assign status_o.is_target = tgt_q;

endmodule

/* rtl/vision_pd_heading_controller.sv */
// ----------------------------------------------------------------------------
// vision_pd_heading_controller
// Marker pose tracking and PD steering for a differential-drive robot.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request: tuser is req_type (0 pose, 1 target) and
//   tdata holds the corner and target coordinates. m_axis returns one result
//   per request with heading, bearing, distance and both drives in tdata and
//   powers_fresh in tuser. cfg writes max_power, p_gain, d_gain and
//   base_points_down by index; they are taken when written, and the user
//   must write them only while idle; the block itself does not enforce it.
// Sequence:
//   the vectoring CORDIC shares one micro-rotation unit, one step per
//   cycle; a target request adds the PD steps before its result is pushed.
//   A new request is accepted only after the previous one has been pushed.
// Reset:
//   all held pose, bearing, distance and drive state clears to zero and the
//   registers return to max_power 1000, p_gain 1.0, d_gain 0, base up.
// Stall:
//   a finished result waits in the output register while the next request
//   is already accepted and worked on; that request holds at its push step
//   until the receiver has taken the earlier result.
// ----------------------------------------------------------------------------
module vision_pd_heading_controller #(
  parameter int COORD_WIDTH  = vpd_pkg::COORD_WIDTH_DEF,
  parameter int CORDIC_STEPS = vpd_pkg::CORDIC_STEPS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // a_x, a_y, b_x, b_y, c_x, c_y, target_x, target_y (16 bits each)
  input  logic [vpd_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // req_type
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // heading_deg[14:0], bearing_deg[29:15], target_distance[46:30],
  // left_power[57:47], right_power[68:58], zero pad
  output logic [vpd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // powers_fresh
  output logic                            m_axis_tuser,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [vpd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [vpd_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  vpd_pkg::cmd_t    cmd;
  vpd_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  vpd_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  vpd_datapath #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .req_type_i (s_axis_tuser),
    .in_data_i  (s_axis_tdata),
    .cfg_we_i   (cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata),
    .out_fresh_o(m_axis_tuser)
  );

endmodule

/* rtl/vpd_checker.sv */
// ----------------------------------------------------------------------------
// vpd_checker
// Port-level checks for the vision PD heading controller.
// ----------------------------------------------------------------------------
module vpd_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [vpd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tuser
);

  logic signed [14:0] bearing;
  logic signed [10:0] left_pwr, right_pwr;
  assign bearing   = m_axis_tdata[29:15];
  assign left_pwr  = m_axis_tdata[57:47];
  assign right_pwr = m_axis_tdata[68:58];

  // result holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one request in flight: ready drops after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while busy");

  // bearing is wrapped to half a turn
  a_bearing_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> bearing >= -15'sd11520 && bearing <= 15'sd11520)
    else $error("bearing out of range");

  // on a fresh result the outer drive runs at max power, so one is non-negative
  a_turn_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> !left_pwr[10] || !right_pwr[10])
    else $error("both drives negative");

endmodule

bind vision_pd_heading_controller vpd_checker u_vpd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

/* sim/tb_vision_pd_heading_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vision_pd_heading_controller
// Self-checking bench for the vision PD heading controller. A directed table
// covers reset state, zero vectors, coordinate extremes and wrap of the
// bearing. Random pose and target requests follow under several register
// settings. Each result is checked per field against a typed value or an
// in-bench CORDIC and PD predictor, with random idling on both stream sides.
// ----------------------------------------------------------------------------
module tb_vision_pd_heading_controller;

  localparam int STEPS       = 16;
  localparam int DRAIN_WAIT  = 40;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 315;
  localparam bit REQ_POSE    = 1'b0;
  localparam bit REQ_TARGET  = 1'b1;

  // arctan(2^-i) in 1/65536 degree
  localparam longint ATAN_STEP [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef struct packed {
    logic [vpd_pkg::HEAD_W-1:0] heading;
    logic [vpd_pkg::HEAD_W-1:0] bearing;
    logic [vpd_pkg::DIST_W-1:0] distance;
    logic [vpd_pkg::PWR_W-1:0]  left;
    logic [vpd_pkg::PWR_W-1:0]  right;
    logic                       fresh;
  } drive_result_t;

  typedef struct {
    bit                            req;
    logic [vpd_pkg::IN_DATA_W-1:0] data;
    bit                            typed;
    drive_result_t                 res;
  } stim_row_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [vpd_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                           s_axis_tuser = 1'b0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [vpd_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                           m_axis_tuser;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [vpd_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [vpd_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  drive_result_t pending_results[$];
  int  errors = 0;
  int  cycles = 0;
  bit  busy_idle = 1'b1;

  // predictor registers and state
  logic [9:0]         pwr_max;
  logic signed [15:0] kp, kd;
  logic               base_down;
  longint             ctr_x, ctr_y;
  int                 head_q, bear_q, bear_prev, dist_q, left_q, right_q;

  vision_pd_heading_controller dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  // vectoring cordic, angle in 1/65536 degree
  function automatic longint cordic_vec(longint xi, longint yi, output longint mag);
    longint x, y, z, t, xs, ys;
    x = xi * 256;
    y = yi * 256;
    z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 5898240;
      end else begin
        t = x; x = -y; y = t; z = -5898240;
      end
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += ATAN_STEP[i];
      end else begin
        x -= ys; y += xs; z -= ATAN_STEP[i];
      end
    end
    mag = x;
    return z;
  endfunction

  // angle against the base vector in 1/64 degree, length in whole coordinate units
  function automatic int base_angle_of(longint vx, longint vy, int zero_val,
                                       output longint mag);
    longint by, m, th, d;
    by = base_down ? vy : -vy;
    if (vx == 0 && vy == 0) begin
      mag = 0;
      return zero_val;
    end
    th = cordic_vec(by, (vx < 0) ? -vx : vx, m);
    d = (vx < 0) ? 64'sd11796480 + th : 64'sd11796480 - th;
    mag = (m * 2547003 + (64'sd1 <<< 29)) >>> 30;
    return int'((d + 512) >>> 10);
  endfunction

  function automatic int round_drive(longint r);
    if (r >= 0) return int'((r + 8192) >>> 14);
    return -int'(((-r) + 8192) >>> 14);
  endfunction

  // advance the predictor by one request and return its result
  function automatic drive_result_t predict_drive(bit req,
                                                  logic [vpd_pkg::IN_DATA_W-1:0] d);
    drive_result_t res;
    longint mag, vx, vy, mp, lim, u, l, r;
    int ta, turn;
    if (req == REQ_POSE) begin
      ctr_x  = (longint'(d[15:0]) + longint'(d[79:64])) >>> 1;
      ctr_y  = (longint'(d[31:16]) + longint'(d[95:80])) >>> 1;
      head_q = base_angle_of(longint'(d[47:32]) - longint'(d[79:64]),
                             longint'(d[63:48]) - longint'(d[95:80]), 0, mag);
    end else begin
      vx   = longint'(d[111:96]) - ctr_x;
      vy   = longint'(d[127:112]) - ctr_y;
      mp   = (pwr_max > 10'd1000) ? 1000 : longint'(pwr_max);
      lim  = mp * 16384;
      ta   = base_angle_of(vx, vy, 11520, mag);
      turn = ta - head_q;
      if (turn > 11520) turn -= 23040;
      else if (turn < -11520) turn += 23040;
      dist_q    = (mag > 131071) ? 131071 : int'(mag);
      bear_prev = bear_q;
      bear_q    = turn;
      u = longint'(kp) * bear_q + longint'(kd) * longint'(bear_prev - bear_q);
      l = lim + u;
      r = lim - u;
      if (l > lim) l = lim; else if (l < -lim) l = -lim;
      if (r > lim) r = lim; else if (r < -lim) r = -lim;
      if (u > 0) begin
        left_q  = int'(mp);
        right_q = round_drive(r);
      end else begin
        left_q  = round_drive(l);
        right_q = int'(mp);
      end
    end
    res.heading  = head_q[vpd_pkg::HEAD_W-1:0];
    res.bearing  = bear_q[vpd_pkg::HEAD_W-1:0];
    res.distance = dist_q[vpd_pkg::DIST_W-1:0];
    res.left     = left_q[vpd_pkg::PWR_W-1:0];
    res.right    = right_q[vpd_pkg::PWR_W-1:0];
    res.fresh    = req;
    return res;
  endfunction

  function automatic logic [vpd_pkg::IN_DATA_W-1:0] pack_coords(
      logic [15:0] ax, ay, bx, by, cx, cy, tx, ty);
    return {ty, tx, cy, cx, by, bx, ay, ax};
  endfunction

  // send one request, predicting at the accepting edge
  task automatic send_request(bit req, logic [vpd_pkg::IN_DATA_W-1:0] d, bit typed,
                              drive_result_t typed_res);
    drive_result_t res;
    while (busy_idle && $urandom_range(99) < 15) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= req;
    do @(posedge clk_i); while (!s_axis_tready);
    res = predict_drive(req, d);
    pending_results.push_back(typed ? typed_res : res);
  endtask

  task automatic write_reg(logic [vpd_pkg::CFG_IDX_W-1:0] idx,
                           logic [vpd_pkg::CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      vpd_pkg::REG_MAX_POWER: pwr_max   = val[9:0];
      vpd_pkg::REG_P_GAIN:    kp        = val;
      vpd_pkg::REG_D_GAIN:    kd        = val;
      vpd_pkg::REG_BASE_DOWN: base_down = val[0];
      default: ;
    endcase
  endtask

  // wait for every result and the pipeline to settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    cfg_valid_i   <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // random request: mostly coherent marker poses with random target points
  task automatic send_random();
    logic [15:0] cx, cy, sz, ox, oy, ax, ay, bx, by, ccx, ccy;
    bit req;
    req = ($urandom_range(99) < 35) ? REQ_POSE : REQ_TARGET;
    if ($urandom_range(99) < 25) begin
      send_request(req, {$urandom, $urandom, $urandom, $urandom}, 1'b0, '0);
    end else begin
      cx  = 16'($urandom_range(60000, 4000));
      cy  = 16'($urandom_range(60000, 4000));
      sz  = 16'($urandom_range(1500, 0));
      ox  = 16'($urandom_range(2 * sz, 0)) - sz;
      oy  = 16'($urandom_range(2 * sz, 0)) - sz;
      ax  = cx - oy; ay = cy - ox;
      ccx = cx + oy; ccy = cy + ox;
      bx  = ccx + ox; by = ccy - oy;
      send_request(req, pack_coords(ax, ay, bx, by, ccx, ccy,
                   16'($urandom_range(65535)), 16'($urandom_range(65535))),
                   1'b0, '0);
    end
  endtask

  // result checker and receiver stalls
  always @(posedge clk_i) begin
    drive_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.heading  = m_axis_tdata[14:0];
      got.bearing  = m_axis_tdata[29:15];
      got.distance = m_axis_tdata[46:30];
      got.left     = m_axis_tdata[57:47];
      got.right    = m_axis_tdata[68:58];
      got.fresh    = m_axis_tuser;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.heading !== want.heading) begin
          $display("%0t: heading exp %0d got %0d", $time, want.heading, got.heading);
          errors++;
        end
        if (got.bearing !== want.bearing) begin
          $display("%0t: bearing exp %0d got %0d", $time,
                   $signed(want.bearing), $signed(got.bearing));
          errors++;
        end
        if (got.distance !== want.distance) begin
          $display("%0t: distance exp %0d got %0d", $time, want.distance,
                   got.distance);
          errors++;
        end
        if (got.left !== want.left) begin
          $display("%0t: left exp %0d got %0d", $time,
                   $signed(want.left), $signed(got.left));
          errors++;
        end
        if (got.right !== want.right) begin
          $display("%0t: right exp %0d got %0d", $time,
                   $signed(want.right), $signed(got.right));
          errors++;
        end
        if (got.fresh !== want.fresh) begin
          $display("%0t: fresh exp %0d got %0d", $time, want.fresh, got.fresh);
          errors++;
        end
      end
    end
    m_axis_tready <= !(busy_idle && $urandom_range(99) < 15);
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    stim_row_t rows[14];
    pwr_max = 10'd1000; kp = 16'sd256; kd = 16'sd0; base_down = 1'b0;
    ctr_x = 0; ctr_y = 0;
    head_q = 0; bear_q = 0; bear_prev = 0; dist_q = 0; left_q = 0; right_q = 0;

    // directed table: reset state, zero vectors, extremes, wrap
    rows[0]  = '{REQ_POSE, '0, 1'b1, '{0, 0, 0, 0, 0, 1'b0}};
    rows[1]  = '{REQ_TARGET, '0, 1'b1, '{0, 11520, 0, 1000, 820, 1'b1}};
    rows[2]  = '{REQ_TARGET, '1, 1'b0, '0};
    rows[3]  = '{REQ_TARGET, '1, 1'b0, '0};
    rows[4]  = '{REQ_POSE, pack_coords(16'h1000, 16'h1000, 16'h3000, 16'h1000,
                 16'h3000, 16'h3000, 0, 0), 1'b0, '0};
    rows[5]  = '{REQ_TARGET, pack_coords(0, 0, 0, 0, 0, 0, 16'h2000, 16'h0000),
                 1'b0, '0};
    rows[6]  = '{REQ_TARGET, pack_coords(0, 0, 0, 0, 0, 0, 16'h2000, 16'hFFFF),
                 1'b0, '0};
    rows[7]  = '{REQ_TARGET, pack_coords(0, 0, 0, 0, 0, 0, 16'h0000, 16'h2000),
                 1'b0, '0};
    rows[8]  = '{REQ_TARGET, pack_coords(0, 0, 0, 0, 0, 0, 16'hFFFF, 16'h2000),
                 1'b0, '0};
    rows[9]  = '{REQ_POSE, pack_coords(16'h0000, 16'h0000, 16'h0000, 16'hFFFF,
                 16'hFFFF, 16'hFFFF, 0, 0), 1'b0, '0};
    rows[10] = '{REQ_TARGET, pack_coords(0, 0, 0, 0, 0, 0, 16'h7FFF, 16'h7FFF),
                 1'b0, '0};
    rows[11] = '{REQ_POSE, pack_coords(16'hFFFF, 16'hFFFF, 16'h1234, 16'h5678,
                 16'h1234, 16'h5678, 0, 0), 1'b0, '0};
    rows[12] = '{REQ_TARGET, pack_coords(0, 0, 0, 0, 0, 0, 16'hFFFF, 16'h0000),
                 1'b0, '0};
    rows[13] = '{REQ_TARGET, pack_coords(0, 0, 0, 0, 0, 0, 16'h0000, 16'hFFFF),
                 1'b0, '0};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_request(rows[i].req, rows[i].data, rows[i].typed, rows[i].res);

    // random phases, each under its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      busy_idle = (ph != 2);
      case (ph)
        0: begin
          write_reg(vpd_pkg::REG_MAX_POWER, 16'd1000);
          write_reg(vpd_pkg::REG_P_GAIN, 16'sd256);
          write_reg(vpd_pkg::REG_D_GAIN, 16'sd128);
          write_reg(vpd_pkg::REG_BASE_DOWN, 16'd0);
        end
        1: begin
          write_reg(vpd_pkg::REG_MAX_POWER, 16'd0);
          write_reg(vpd_pkg::REG_P_GAIN, 16'h8000);
          write_reg(vpd_pkg::REG_D_GAIN, 16'h7FFF);
          write_reg(vpd_pkg::REG_BASE_DOWN, 16'd1);
        end
        2: begin
          write_reg(vpd_pkg::REG_MAX_POWER, 16'hFFFF);
          write_reg(vpd_pkg::REG_P_GAIN, 16'h7FFF);
          write_reg(vpd_pkg::REG_D_GAIN, 16'h8000);
          write_reg(vpd_pkg::REG_BASE_DOWN, 16'hFFFE);
        end
        3: begin
          write_reg(vpd_pkg::REG_MAX_POWER, 16'd1023);
          write_reg(vpd_pkg::REG_P_GAIN, 16'sd8);
          write_reg(vpd_pkg::REG_D_GAIN, -16'sd64);
          write_reg(vpd_pkg::REG_BASE_DOWN, 16'd1);
        end
        default: begin
          write_reg(vpd_pkg::REG_MAX_POWER, vpd_pkg::CFG_DATA_W'($urandom_range(1023)));
          write_reg(vpd_pkg::REG_P_GAIN, vpd_pkg::CFG_DATA_W'($urandom));
          write_reg(vpd_pkg::REG_D_GAIN, vpd_pkg::CFG_DATA_W'($urandom));
          write_reg(vpd_pkg::REG_BASE_DOWN, vpd_pkg::CFG_DATA_W'($urandom));
        end
      endcase
      cfg_valid_i <= 1'b0;
      for (int n = 0; n < PHASE_ITEMS; n++) send_random();
    end

    drain();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
